// ===== src/sti_pkg.sv =====
// ----------------------------------------------------------------------------
// sti_pkg
// shared types and constants of the spectrum table interpolator
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int DefMaxRows  = 64;
  localparam int DefMaxFreqs = 64;
  localparam int XW          = 32;
  localparam int YW          = 32;
  localparam int FracBits    = 30;
  localparam int QW          = XW + FracBits;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 7;
  localparam int RowFieldW   = 6;
  localparam int SlotFieldW  = 6;

  localparam logic [CfgIdxW-1:0] CfgRowsIdx  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFreqsIdx = 2'd1;

  typedef enum logic [1:0] {
    ACT_WR_INT = 2'd0,
    ACT_WR_SMP = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXTRAP     = 2'd1,
    ST_ZERO_WIDTH = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SCAN0,
    BK_SCAN,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_RD_LO,
    BK_RD_HI,
    BK_DIFF,
    BK_MUL0,
    BK_MUL1,
    BK_MUL2,
    BK_RES,
    BK_ZERO
  } back_state_e;

  typedef struct packed {
    action_e                act;
    logic [RowFieldW-1:0]   row;
    logic [SlotFieldW-1:0]  slot;
    logic [XW-1:0]          x;
    logic signed [YW-1:0]   re;
    logic signed [YW-1:0]   im;
  } cmd_t;

endpackage

// ===== src/sti_front.sv =====
// ----------------------------------------------------------------------------
// sti_front
// accepts items, drops ignored ones and queues the rest for the back end
// ----------------------------------------------------------------------------
module sti_front import sti_pkg::*; #(
  parameter int MAX_ROWS  = DefMaxRows,
  parameter int MAX_FREQS = DefMaxFreqs
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             action_i,
  input  logic [RowFieldW-1:0]   row_index_i,
  input  logic [SlotFieldW-1:0]  freq_slot_i,
  input  logic [XW-1:0]          intensity_value_i,
  input  logic signed [YW-1:0]   sample_re_i,
  input  logic signed [YW-1:0]   sample_im_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  logic                   cmd_pop_i
);

  cmd_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       keep, push, pop;
  cmd_t       cmd;

  always_comb begin
    cmd.act  = action_e'(action_i);
    cmd.row  = row_index_i;
    cmd.slot = freq_slot_i;
    cmd.x    = intensity_value_i;
    cmd.re   = sample_re_i;
    cmd.im   = sample_im_i;
    unique case (cmd.act)
      ACT_WR_INT: keep = (32'(row_index_i) < MAX_ROWS);
      ACT_WR_SMP: keep = (32'(row_index_i) < MAX_ROWS) && (32'(freq_slot_i) < MAX_FREQS);
      ACT_QUERY:  keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cnt_d       = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd;
  end

  assign cmd_o = q_mem[rd_ptr_q];

endmodule

// ===== src/sti_divider.sv =====
// ----------------------------------------------------------------------------
// sti_divider
// restoring divider on magnitudes, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sti_divider import sti_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [QW-1:0] num_i,
  input  logic [XW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);

  localparam int CW = $clog2(QW);

  logic          run_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [XW-1:0] rem_q, den_q;
  logic [QW-1:0] nq_q;
  logic [XW:0]   rem_sh, rem_new;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_q, nq_q[QW-1]};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_new = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      nq_q  <= num_i;
    end else if (run_q) begin
      rem_q <= rem_new[XW-1:0];
      nq_q  <= {nq_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

// ===== src/sti_back.sv =====
// ----------------------------------------------------------------------------
// sti_back
// table stores, bracket search, fraction and per-frequency interpolation
// ----------------------------------------------------------------------------
module sti_back import sti_pkg::*; #(
  parameter int MAX_ROWS  = DefMaxRows,
  parameter int MAX_FREQS = DefMaxFreqs
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  logic [CfgDataW-1:0]   rows_cfg_i,
  input  logic [CfgDataW-1:0]   freqs_cfg_i,
  output logic                  res_valid_o,
  output logic [SlotFieldW-1:0] freq_out_o,
  output logic signed [YW-1:0]  result_re_o,
  output logic signed [YW-1:0]  result_im_o,
  output logic                  last_o,
  output logic [1:0]            status_o
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int Depth = MAX_ROWS * MAX_FREQS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int NW    = $clog2(MAX_ROWS + 1);
  localparam int MW    = $clog2(MAX_FREQS + 1);
  localparam int PW    = QW + XW;

  localparam logic signed [YW+2:0] SatMax = (YW+3)'(64'sd2147483647);
  localparam logic signed [YW+2:0] SatMin = -(YW+3)'(64'sd2147483648);

  back_state_e state_q, state_d;

  logic [XW-1:0]   tab_mem [MAX_ROWS];
  logic [2*YW-1:0] smp_mem [Depth];
  logic [XW-1:0]   tab_rd_q;
  logic [2*YW-1:0] smp_rd_q;
  logic [RW-1:0]   tab_addr;
  logic [AW-1:0]   smp_addr, smp_waddr;
  logic            tab_we, smp_we;

  logic [RW-1:0]   idx_q;
  logic [MW-1:0]   f_q, m_q, m_clamp;
  logic [NW-1:0]   n_q, n_clamp;
  logic            comp_q, res_valid_q;

  logic [XW-1:0]   x_q, hi_q, x0_q, x1_q;
  logic [AW-1:0]   lo_base_q, hi_base_q;
  status_e         status_q;
  logic            neg_frac_q;
  logic signed [YW-1:0] lo_re_q, lo_im_q, res_re_q;
  logic [YW-1:0]   dmag_re_q, dmag_im_q;
  logic            dneg_re_q, dneg_im_q;
  logic [2*XW-1:0] prod_q;
  logic [PW-1:0]   acc_q;

  logic [SlotFieldW-1:0] freq_out_q;
  logic signed [YW-1:0]  result_re_q, result_im_q;
  logic                  last_q;
  status_e               status_out_q;

  logic            bracket, scan_done, is_last;
  logic signed [XW:0] dx, num_s, d_re, d_im;
  logic [XW:0]     num_mag, den_mag;
  logic            div_start, div_done;
  logic [QW-1:0]   quo;
  logic [YW-1:0]   mul_a;
  logic            big, neg;
  logic [XW:0]     qv;
  logic signed [YW+2:0] lo_ext, r_ext;
  logic signed [YW-1:0] r_sat;

  sti_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({num_mag[XW-1:0], {FracBits{1'b0}}}),
    .den_i   (den_mag[XW-1:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // configuration clamps
  always_comb begin
    if (int'(rows_cfg_i) < 2)             n_clamp = NW'(2);
    else if (int'(rows_cfg_i) > MAX_ROWS) n_clamp = NW'(MAX_ROWS);
    else                                  n_clamp = NW'(rows_cfg_i);
    if (int'(freqs_cfg_i) < 1)              m_clamp = MW'(1);
    else if (int'(freqs_cfg_i) > MAX_FREQS) m_clamp = MW'(MAX_FREQS);
    else                                    m_clamp = MW'(freqs_cfg_i);
  end

  // datapath terms
  always_comb begin
    bracket   = (x_q <= hi_q) && (x_q > tab_rd_q);
    scan_done = bracket || ((32'(idx_q) + 1) == 32'(n_q));
    dx        = $signed({1'b0, x1_q}) - $signed({1'b0, x0_q});
    num_s     = $signed({1'b0, x_q}) - $signed({1'b0, x0_q});
    num_mag   = num_s[XW] ? 33'(-num_s) : 33'(num_s);
    den_mag   = dx[XW] ? 33'(-dx) : 33'(dx);
    d_re      = $signed({smp_rd_q[2*YW-1], smp_rd_q[2*YW-1:YW]})
              - $signed({lo_re_q[YW-1], lo_re_q});
    d_im      = $signed({smp_rd_q[YW-1], smp_rd_q[YW-1:0]})
              - $signed({lo_im_q[YW-1], lo_im_q});
    mul_a     = comp_q ? dmag_im_q : dmag_re_q;
    big       = |acc_q[PW-1:2*XW-1];
    qv        = acc_q[2*XW-2:FracBits];
    neg       = (comp_q ? dneg_im_q : dneg_re_q) ^ neg_frac_q;
    lo_ext    = comp_q ? (YW+3)'(lo_im_q) : (YW+3)'(lo_re_q);
    r_ext     = neg ? (lo_ext - $signed({2'b00, qv})) : (lo_ext + $signed({2'b00, qv}));
    if (big)                 r_sat = neg ? YW'(SatMin) : YW'(SatMax);
    else if (r_ext > SatMax) r_sat = YW'(SatMax);
    else if (r_ext < SatMin) r_sat = YW'(SatMin);
    else                     r_sat = r_ext[YW-1:0];
    is_last   = ((32'(f_q) + 1) == 32'(m_q));
    smp_waddr = AW'(32'(cmd_i.row) * MAX_FREQS + 32'(cmd_i.slot));
  end

  // next state and controls
  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    tab_we    = 1'b0;
    smp_we    = 1'b0;
    div_start = 1'b0;
    tab_addr  = '0;
    smp_addr  = lo_base_q + AW'(f_q);
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.act)
            ACT_WR_INT: tab_we = 1'b1;
            ACT_WR_SMP: smp_we = 1'b1;
            ACT_QUERY:  state_d = BK_SCAN0;
            default:    state_d = BK_IDLE;
          endcase
        end
      end
      BK_SCAN0: begin
        tab_addr = RW'(1);
        state_d  = BK_SCAN;
      end
      BK_SCAN: begin
        tab_addr = idx_q + RW'(1);
        if (scan_done) state_d = BK_DIV_GO;
      end
      BK_DIV_GO: begin
        if (dx == '0) begin
          state_d = BK_ZERO;
        end else begin
          div_start = 1'b1;
          state_d   = BK_DIV_WAIT;
        end
      end
      BK_DIV_WAIT: if (div_done) state_d = BK_RD_LO;
      BK_RD_LO:    state_d = BK_RD_HI;
      BK_RD_HI: begin
        smp_addr = hi_base_q + AW'(f_q);
        state_d  = BK_DIFF;
      end
      BK_DIFF: state_d = BK_MUL0;
      BK_MUL0: state_d = BK_MUL1;
      BK_MUL1: state_d = BK_MUL2;
      BK_MUL2: state_d = BK_RES;
      BK_RES: begin
        if (!comp_q)      state_d = BK_MUL0;
        else if (is_last) state_d = BK_IDLE;
        else              state_d = BK_RD_LO;
      end
      BK_ZERO: if (is_last) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      f_q         <= '0;
      comp_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      case (state_q)
        BK_IDLE:     idx_q <= '0;
        BK_SCAN0:    idx_q <= RW'(1);
        BK_SCAN:     if (!scan_done) idx_q <= idx_q + RW'(1);
        BK_DIV_GO:   f_q <= '0;
        BK_RES: begin
          comp_q <= ~comp_q;
          if (comp_q) begin
            res_valid_q <= 1'b1;
            f_q         <= f_q + MW'(1);
          end
        end
        BK_ZERO: begin
          res_valid_q <= 1'b1;
          f_q         <= f_q + MW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[RW'(cmd_i.row)] <= cmd_i.x;
    tab_rd_q <= tab_mem[tab_addr];
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) smp_mem[smp_waddr] <= {cmd_i.re, cmd_i.im};
    smp_rd_q <= smp_mem[smp_addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        x_q <= cmd_i.x;
        n_q <= n_clamp;
        m_q <= m_clamp;
      end
      BK_SCAN0: hi_q <= tab_rd_q;
      BK_SCAN: begin
        hi_q <= tab_rd_q;
        if (scan_done) begin
          x1_q      <= hi_q;
          x0_q      <= tab_rd_q;
          status_q  <= bracket ? ST_OK : ST_EXTRAP;
          hi_base_q <= AW'((32'(idx_q) - 1) * MAX_FREQS);
          lo_base_q <= AW'(32'(idx_q) * MAX_FREQS);
        end
      end
      BK_DIV_GO: begin
        neg_frac_q <= num_s[XW] ^ dx[XW];
        if (dx == '0) status_q <= ST_ZERO_WIDTH;
      end
      BK_RD_HI: begin
        lo_re_q <= smp_rd_q[2*YW-1:YW];
        lo_im_q <= smp_rd_q[YW-1:0];
      end
      BK_DIFF: begin
        dmag_re_q <= d_re[XW] ? YW'(-d_re) : YW'(d_re);
        dmag_im_q <= d_im[XW] ? YW'(-d_im) : YW'(d_im);
        dneg_re_q <= d_re[XW];
        dneg_im_q <= d_im[XW];
      end
      BK_MUL0: prod_q <= mul_a * quo[XW-1:0];
      BK_MUL1: begin
        acc_q  <= PW'(prod_q);
        prod_q <= mul_a * XW'(quo[QW-1:XW]);
      end
      BK_MUL2: acc_q <= acc_q + PW'({prod_q, {XW{1'b0}}});
      BK_RES: begin
        if (!comp_q) begin
          res_re_q <= r_sat;
        end else begin
          result_re_q  <= res_re_q;
          result_im_q  <= r_sat;
          freq_out_q   <= SlotFieldW'(f_q);
          last_q       <= is_last;
          status_out_q <= status_q;
        end
      end
      BK_ZERO: begin
        result_re_q  <= '0;
        result_im_q  <= '0;
        freq_out_q   <= SlotFieldW'(f_q);
        last_q       <= is_last;
        status_out_q <= status_q;
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign freq_out_o  = freq_out_q;
  assign result_re_o = result_re_q;
  assign result_im_o = result_im_q;
  assign last_o      = last_q;
  assign status_o    = status_out_q;

endmodule

// ===== src/spectrum_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// spectrum_table_interpolator
// table of complex spectra per intensity with linear interpolation on query
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  command   | start_i, busy_o            | action, row, slot, intensity, re/im
//  config    | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//  result    | res_valid_o strobe         | freq_out, result re/im, last, status
//
//  writes are taken by the back end while idle; a query scans the rows
//  one per table read, runs a bit-serial divider on the fraction, then
//  interpolates each frequency, re then im, on one shared 32x32 multiplier
//  a two-entry queue parts the front from the back; busy_o is high when full
//  no clearing pass after reset; results cannot be stalled
module spectrum_table_interpolator import sti_pkg::*; #(
  parameter int MAX_ROWS  = DefMaxRows,
  parameter int MAX_FREQS = DefMaxFreqs
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            action_i,
  input  logic [RowFieldW-1:0]  row_index_i,
  input  logic [SlotFieldW-1:0] freq_slot_i,
  input  logic [XW-1:0]         intensity_value_i,
  input  logic signed [YW-1:0]  sample_re_i,
  input  logic signed [YW-1:0]  sample_im_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output logic                  res_valid_o,
  output logic [SlotFieldW-1:0] freq_out_o,
  output logic signed [YW-1:0]  result_re_o,
  output logic signed [YW-1:0]  result_im_o,
  output logic                  last_o,
  output logic [1:0]            status_o
);

  logic [CfgDataW-1:0] rows_q, freqs_q;
  logic                cmd_valid, cmd_pop;
  cmd_t                cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CfgDataW'(64);
      freqs_q <= CfgDataW'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgRowsIdx)  rows_q  <= cfg_data_i;
      if (cfg_index_i == CfgFreqsIdx) freqs_q <= cfg_data_i;
    end
  end

  sti_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_FREQS (MAX_FREQS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .action_i          (action_i),
    .row_index_i       (row_index_i),
    .freq_slot_i       (freq_slot_i),
    .intensity_value_i (intensity_value_i),
    .sample_re_i       (sample_re_i),
    .sample_im_i       (sample_im_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_pop_i         (cmd_pop)
  );

  sti_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_FREQS (MAX_FREQS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rows_cfg_i  (rows_q),
    .freqs_cfg_i (freqs_q),
    .res_valid_o (res_valid_o),
    .freq_out_o  (freq_out_o),
    .result_re_o (result_re_o),
    .result_im_o (result_im_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule

// ===== tb/spectrum_table_interpolator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrum_table_interpolator_tb
// self-checking bench: loads the table entries that queries can reach, runs
// directed and random writes and queries in bursts under several row and
// frequency counts, and compares every interpolated result with a predictor
// kept in the bench
// ----------------------------------------------------------------------------
module spectrum_table_interpolator_tb;
  import sti_pkg::*;

  localparam int NRows      = 64;
  localparam int NFreqs     = 64;
  localparam int SettleCyc  = 900;
  localparam int CycleLimit = 2000000;
  localparam int NoStatus   = -1;

  localparam logic [CfgIdxW-1:0] CfgSpareIdxA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareIdxB = 2'd3;

  typedef struct {
    logic [SlotFieldW-1:0] freq;
    logic signed [YW-1:0]  re;
    logic signed [YW-1:0]  im;
    logic                  last;
    logic [1:0]            status;
  } spec_point_t;

  typedef struct {
    action_e         act;
    int              row;
    int              slot;
    logic [XW-1:0]   x;
    logic [YW-1:0]   re;
    logic [YW-1:0]   im;
    int              typed_st;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [1:0]            action_i = ACT_NOP;
  logic [RowFieldW-1:0]  row_index_i = '0;
  logic [SlotFieldW-1:0] freq_slot_i = '0;
  logic [XW-1:0]         intensity_value_i = '0;
  logic signed [YW-1:0]  sample_re_i = '0;
  logic signed [YW-1:0]  sample_im_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  res_valid_o;
  logic [SlotFieldW-1:0] freq_out_o;
  logic signed [YW-1:0]  result_re_o;
  logic signed [YW-1:0]  result_im_o;
  logic                  last_o;
  logic [1:0]            status_o;

  spectrum_table_interpolator u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [XW-1:0]        int_tab [NRows];
  logic signed [YW-1:0] smp_re [NRows*NFreqs];
  logic signed [YW-1:0] smp_im [NRows*NFreqs];
  int                   rows_cfg = 64;
  int                   freqs_cfg = 64;

  spec_point_t spectrum_q [$];
  int          typed_st_drv = NoStatus;
  logic        cmd_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  int          mismatches = 0;
  int          n_results = 0;
  int          n_queries = 0;
  int          n_extrap = 0;
  int          n_zero = 0;
  longint      cycles = 0;

  function automatic logic signed [YW-1:0] lerp(longint y0, longint y1, longint frac);
    longint          d;
    longint unsigned ad;
    longint unsigned af;
    logic [127:0]    p;
    longint unsigned q;
    longint          r;
    d  = y1 - y0;
    ad = (d < 0) ? -d : d;
    af = (frac < 0) ? -frac : frac;
    p  = 128'(ad) * 128'(af);
    q  = (p[127:64] != 0) ? (64'd1 << 40) : (p[63:0] >> FracBits);
    r  = ((d < 0) != (frac < 0)) ? y0 - longint'(q) : y0 + longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[YW-1:0];
  endfunction

  function automatic void predict_query(logic [XW-1:0] x, int typed_st);
    int          n;
    int          m;
    int          i;
    bit          found;
    longint      x0;
    longint      dx;
    longint      frac;
    status_e     st;
    spec_point_t pt;
    n = (rows_cfg < 2) ? 2 : (rows_cfg > NRows ? NRows : rows_cfg);
    m = (freqs_cfg < 1) ? 1 : (freqs_cfg > NFreqs ? NFreqs : freqs_cfg);
    found = 1'b0;
    for (i = 0; i + 1 < n; i++) begin
      if (x <= int_tab[i] && x > int_tab[i+1]) begin
        found = 1'b1;
        break;
      end
    end
    if (!found) i = n - 2;
    x0   = longint'(int_tab[i+1]);
    dx   = longint'(int_tab[i]) - x0;
    st   = found ? ST_OK : ST_EXTRAP;
    frac = 0;
    if (dx == 0) st = ST_ZERO_WIDTH;
    else frac = ((longint'(x) - x0) * (64'sd1 <<< FracBits)) / dx;
    if (st == ST_EXTRAP) n_extrap++;
    if (st == ST_ZERO_WIDTH) n_zero++;
    for (int f = 0; f < m; f++) begin
      pt.freq   = f[SlotFieldW-1:0];
      pt.last   = (f + 1 == m);
      pt.status = st;
      pt.re     = '0;
      pt.im     = '0;
      if (st != ST_ZERO_WIDTH) begin
        pt.re = lerp(smp_re[(i+1)*NFreqs+f], smp_re[i*NFreqs+f], frac);
        pt.im = lerp(smp_im[(i+1)*NFreqs+f], smp_im[i*NFreqs+f], frac);
      end
      if (typed_st != NoStatus) begin
        pt.status = typed_st[1:0];
        if (typed_st == ST_ZERO_WIDTH) begin
          pt.re = '0;
          pt.im = '0;
        end
      end
      spectrum_q = {spectrum_q, pt};
    end
  endfunction

  // transfer monitor and result checker
  always @(posedge clk_i) begin
    spec_point_t e;
    cycles <= cycles + 1;
    cmd_taken <= start_i && !busy_o;
    cfg_taken <= cfg_valid_i && cfg_ready_o;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgRowsIdx) rows_cfg = cfg_data_i;
      else if (cfg_index_i == CfgFreqsIdx) freqs_cfg = cfg_data_i;
    end
    if (start_i && !busy_o) begin
      case (action_e'(action_i))
        ACT_WR_INT: int_tab[row_index_i] = intensity_value_i;
        ACT_WR_SMP: begin
          smp_re[row_index_i*NFreqs+freq_slot_i] = sample_re_i;
          smp_im[row_index_i*NFreqs+freq_slot_i] = sample_im_i;
        end
        ACT_QUERY: begin
          n_queries++;
          predict_query(intensity_value_i, typed_st_drv);
        end
        default: ;
      endcase
    end
    if (res_valid_o) begin
      n_results++;
      if (spectrum_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result freq %0d", freq_out_o);
      end else begin
        e = spectrum_q.pop_front();
        if (freq_out_o !== e.freq || result_re_o !== e.re || result_im_o !== e.im ||
            last_o !== e.last || status_o !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp f%0d %h %h l%0d s%0d, got f%0d %h %h l%0d s%0d",
                     e.freq, e.re, e.im, e.last, e.status, freq_out_o, result_re_o,
                     result_im_o, last_o, status_o);
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("spectrum_table_interpolator: mismatch");
      $finish;
    end
  end

  // keeps start high across a burst, drops it in gaps
  task automatic send(action_e act, int row, int slot, logic [XW-1:0] x,
                      logic [YW-1:0] re, logic [YW-1:0] im, int typed_st, bit gaps);
    start_i           <= 1'b1;
    action_i          <= act;
    row_index_i       <= row[RowFieldW-1:0];
    freq_slot_i       <= slot[SlotFieldW-1:0];
    intensity_value_i <= x;
    sample_re_i       <= re;
    sample_im_i       <= im;
    typed_st_drv      <= typed_st;
    do @(negedge clk_i); while (!cmd_taken);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (spectrum_q.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CfgDataW-1:0];
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_burst(int count);
    int            n;
    int            r;
    longint        hi;
    longint        lo;
    logic [XW-1:0] x;
    for (int k = 0; k < count; k++) begin
      n = (rows_cfg < 2) ? 2 : (rows_cfg > NRows ? NRows : rows_cfg);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        lo = int_tab[n-1];
        hi = int_tab[0];
        x = (hi > lo) ? XW'(lo + ({$urandom, $urandom} % (hi - lo + 1))) : XW'(lo);
        if ($urandom_range(0, 7) == 0) x = $urandom;
        if ($urandom_range(0, 7) == 0) x = int_tab[$urandom_range(0, n-1)];
        send(ACT_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), x,
             $urandom, $urandom, NoStatus, 1'b1);
      end else if (r < 60) begin
        r  = $urandom_range(0, 63);
        hi = (r == 0) ? 64'hFFFF_FFFF : int_tab[r-1];
        lo = (r == 63) ? 0 : int_tab[r+1];
        x = (hi > lo + 1) ? XW'(lo + 1 + ({$urandom, $urandom} % (hi - lo - 1))) : XW'(lo);
        if ($urandom_range(0, 9) == 0) x = $urandom;
        send(ACT_WR_INT, r, $urandom_range(0, 63), x, $urandom, $urandom,
             NoStatus, 1'b1);
      end else if (r < 95) begin
        send(ACT_WR_SMP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
             $urandom, $urandom, NoStatus, 1'b1);
      end else begin
        send(ACT_NOP, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
             $urandom, $urandom, NoStatus, 1'b1);
      end
    end
  endtask

  stim_row_t directed [20] = '{
    '{ACT_QUERY,  0, 0, 32'hF000_0000, '0, '0, ST_OK},
    '{ACT_QUERY,  0, 0, 32'h0000_0000, '0, '0, ST_EXTRAP},
    '{ACT_QUERY,  0, 0, 32'hFFFF_FFFF, '0, '0, ST_EXTRAP},
    '{ACT_WR_SMP, 0, 0, '0, 32'h7FFF_FFFF, 32'h8000_0000, NoStatus},
    '{ACT_WR_SMP, 1, 0, '0, 32'h8000_0000, 32'h7FFF_FFFF, NoStatus},
    '{ACT_WR_SMP, 0, 2, '0, 32'h0000_0000, 32'hFFFF_FFFF, NoStatus},
    '{ACT_QUERY,  0, 0, 32'hEE80_0000, '0, '0, NoStatus},
    '{ACT_QUERY,  0, 0, 32'hED00_0001, '0, '0, NoStatus},
    '{ACT_WR_SMP, 2, 0, '0, 32'h7FFF_FFFF, 32'h8000_0000, NoStatus},
    '{ACT_WR_SMP, 3, 0, '0, 32'h8000_0000, 32'h7FFF_FFFF, NoStatus},
    '{ACT_QUERY,  0, 0, 32'hFFFF_FFFF, '0, '0, ST_EXTRAP},
    '{ACT_QUERY,  0, 0, 32'h0000_0001, '0, '0, ST_EXTRAP},
    '{ACT_NOP,    63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NoStatus},
    '{ACT_WR_SMP, 63, 63, '0, 32'h5555_5555, 32'hAAAA_AAAA, NoStatus},
    '{ACT_WR_INT, 63, 0, 32'h0000_0000, '0, '0, NoStatus},
    '{ACT_WR_INT, 2, 0, 32'hE700_0000, '0, '0, NoStatus},
    '{ACT_QUERY,  0, 0, 32'h0000_0000, '0, '0, ST_ZERO_WIDTH},
    '{ACT_QUERY,  0, 0, 32'hE700_0000, '0, '0, ST_ZERO_WIDTH},
    '{ACT_WR_INT, 2, 0, 32'hEA00_0000, '0, '0, NoStatus},
    '{ACT_QUERY,  0, 0, 32'hE800_0000, '0, '0, NoStatus}
  };

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fill every entry a query can reach under the row and freq counts below
    for (int r = 0; r < NRows; r++)
      send(ACT_WR_INT, r, 0, 32'hF000_0000 - r * 32'h0300_0000, '0, '0, NoStatus, 1'b0);
    for (int r = 0; r < NRows; r++)
      for (int f = 0; f < NFreqs; f++)
        if (r < 2 || f == 0 || (r < 4 && f < 3))
          send(ACT_WR_SMP, r, f, '0, $urandom, $urandom, NoStatus, 1'b0);
    settle();

    write_reg(CfgRowsIdx, 4);
    write_reg(CfgFreqsIdx, 3);
    foreach (directed[k])
      send(directed[k].act, directed[k].row, directed[k].slot, directed[k].x,
           directed[k].re, directed[k].im, directed[k].typed_st, 1'b1);
    settle();

    write_reg(CfgRowsIdx, 0);
    write_reg(CfgFreqsIdx, 127);
    write_reg(CfgSpareIdxA, 5);
    write_reg(CfgSpareIdxB, 9);
    random_burst(30);
    settle();
    write_reg(CfgRowsIdx, 127);
    write_reg(CfgFreqsIdx, 0);
    random_burst(30);
    settle();
    for (int p = 0; p < 2; p++) begin
      write_reg(CfgRowsIdx, $urandom_range(2, 64));
      write_reg(CfgFreqsIdx, 1);
      random_burst(21);
      settle();
    end

    $display("queries %0d (extrapolated %0d, zero width %0d), results checked %0d",
             n_queries, n_extrap, n_zero, n_results);
    $display("row counts 0..127 and freq counts 0..127 exercised, mismatches %0d",
             mismatches);
    if (mismatches == 0 && spectrum_q.size() == 0)
      $display("spectrum_table_interpolator: match");
    else
      $display("spectrum_table_interpolator: mismatch");
    $finish;
  end

endmodule
